// File: rtl/tmwp_pkg.sv
// shared types and constants for the table-mixing word generator
package tmwp_pkg;

    localparam int TABLE_WORDS = 256;
    localparam int AW = $clog2(TABLE_WORDS);
    localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_DRAW = 2'd3;

    localparam logic [0:0] REG_EXTRA_LOOKUP = 1'd0;
    localparam logic [0:0] REG_ROTATION_SWITCH = 1'd1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,     // write golden/zero at clr address
        OP_CLR_REGS,  // reset chaining registers
        OP_LOAD_RD,   // read table at word_index
        OP_LOAD_WR,   // merge seed bytes and write back
        OP_R0,        // round: read T[d]
        OP_R1,        // round: compute, write T[d]
        OP_R2,        // round: read T[b] or T[r]
        OP_ROT,       // round: finish d, write buffer
        OP_DRAW_RD,   // read buffer at draw pointer
        OP_DRAW_PTR   // advance draw pointer
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [AW-1:0] addr;   // clear address or round index
    } cmd_t;

    typedef struct packed {
        logic          ptr_wrap;
        logic [AW-1:0] ptr;
    } stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
        logic [63:0] t;
        t = {x, x} << k;
        return t[63:32];
    endfunction

    function automatic logic [14:0] rot_set(input logic [1:0] s);
        case (s)
            2'd0: rot_set = {5'd30, 5'd13, 5'd24};
            2'd1: rot_set = {5'd5, 5'd19, 5'd20};
            2'd2: rot_set = {5'd21, 5'd4, 5'd10};
            default: rot_set = {5'd29, 5'd15, 5'd6};
        endcase
    endfunction

endpackage

// File: rtl/tmwp_ram.sv
// generic single-port ram with registered read
module tmwp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/tmwp_datapath.sv
// table, buffer and chaining registers of the generator
module tmwp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  tmwp_pkg::cmd_t     cmd,
    input  logic               extra_lookup,
    input  logic               rotation_switch,
    input  logic [5:0]         word_index,
    input  logic [31:0]        seed_word,
    input  logic [3:0]         byte_enable,
    output tmwp_pkg::stat_t    stat,
    output logic [31:0]        buf_word
);
    localparam int AW = tmwp_pkg::AW;

    logic [31:0] b_reg, c_reg, d_reg, e_reg;
    logic [31:0] b_next, c_next, d_next, e_next;
    logic [1:0]  rs_reg, rs_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic        wrap_reg, wrap_next;

    logic          t_we, r_we;
    logic [AW-1:0] t_addr, r_addr;
    logic [31:0]   t_wdata, r_wdata, t_rdata, r_rdata;
    logic [31:0]   mask;
    logic [14:0]   rs;
    logic [31:0]   e_calc, b_calc;

    tmwp_ram #(.WIDTH(32), .DEPTH(tmwp_pkg::TABLE_WORDS)) u_table (
        .aclk(aclk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
    );
    tmwp_ram #(.WIDTH(32), .DEPTH(tmwp_pkg::TABLE_WORDS)) u_buffer (
        .aclk(aclk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata)
    );

    assign rs = tmwp_pkg::rot_set(rs_reg);
    assign e_calc = t_rdata - tmwp_pkg::rotl(b_reg, rs[14:10]);
    assign b_calc = c_reg + tmwp_pkg::rotl(d_reg, rs[4:0]);
    assign buf_word = r_rdata;
    assign stat.ptr = ptr_reg;
    assign stat.ptr_wrap = wrap_reg;

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            mask[8*n +: 8] = {8{byte_enable[n]}};
        end
        t_we = 1'b0;
        r_we = 1'b0;
        t_addr = cmd.addr;
        r_addr = cmd.addr;
        t_wdata = tmwp_pkg::GOLDEN_WORD;
        r_wdata = '0;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        rs_next = rs_reg;
        ptr_next = ptr_reg;
        wrap_next = wrap_reg;
        case (cmd.op)
            tmwp_pkg::OP_CLEAR: begin
                t_we = 1'b1;
                r_we = 1'b1;
            end
            tmwp_pkg::OP_CLR_REGS: begin
                // last clear address is written here as well
                t_we = 1'b1;
                r_we = 1'b1;
                b_next = tmwp_pkg::GOLDEN_WORD;
                c_next = tmwp_pkg::GOLDEN_WORD;
                d_next = tmwp_pkg::GOLDEN_WORD;
                rs_next = '0;
                ptr_next = '0;
                wrap_next = 1'b0;
            end
            tmwp_pkg::OP_LOAD_RD: begin
                t_addr = AW'(word_index);
            end
            tmwp_pkg::OP_LOAD_WR: begin
                t_addr = AW'(word_index);
                t_we = 1'b1;
                t_wdata = (t_rdata & ~mask) | (seed_word & mask);
            end
            tmwp_pkg::OP_R0: begin
                t_addr = d_reg[AW-1:0];
            end
            tmwp_pkg::OP_R1: begin
                t_addr = d_reg[AW-1:0];
                t_we = 1'b1;
                t_wdata = b_reg ^ tmwp_pkg::rotl(c_reg, rs[9:5]);
                e_next = e_calc;
                b_next = b_calc;
                c_next = d_reg + e_calc;
            end
            tmwp_pkg::OP_R2: begin
                // read of the looked-up word issued here, used next cycle
                t_addr = extra_lookup ? b_reg[AW-1:0] : cmd.addr;
            end
            tmwp_pkg::OP_ROT: begin
                // second half of a round: d from the looked-up word
                d_next = e_reg + t_rdata;
                r_we = 1'b1;
                r_wdata = e_reg + t_rdata;
            end
            tmwp_pkg::OP_DRAW_RD: begin
                r_addr = ptr_reg;
            end
            tmwp_pkg::OP_DRAW_PTR: begin
                ptr_next = ptr_reg + 1'b1;
                wrap_next = (ptr_reg == AW'(tmwp_pkg::TABLE_WORDS - 1));
            end
            default: begin
            end
        endcase
        // rotation set update is flagged by an all-ones addr on OP_NONE, when rotation_switch is set
        if (cmd.op == tmwp_pkg::OP_NONE && cmd.addr == '1 && rotation_switch) begin
            rs_next = c_reg[1:0];
        end
        if (cmd.op == tmwp_pkg::OP_NONE && cmd.addr == AW'(1)) begin
            ptr_next = '0;
            wrap_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg <= tmwp_pkg::GOLDEN_WORD;
            c_reg <= tmwp_pkg::GOLDEN_WORD;
            d_reg <= tmwp_pkg::GOLDEN_WORD;
            rs_reg <= '0;
            ptr_reg <= '0;
            wrap_reg <= 1'b0;
        end else begin
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            rs_reg <= rs_next;
            ptr_reg <= ptr_next;
            wrap_reg <= wrap_next;
        end
        e_reg <= e_next;
    end
endmodule

// File: rtl/tmwp_ctrl.sv
// command sequencer of the generator
module tmwp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_cmd,
    input  logic [9:0]      in_count,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_draw,
    output logic            out_load,
    output tmwp_pkg::cmd_t  cmd,
    input  tmwp_pkg::stat_t stat
);
    localparam int AW = tmwp_pkg::AW;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_LOAD_RD, S_LOAD_WR, S_R0, S_R1, S_R2, S_R3,
        S_ROT, S_PTR0, S_D_RD, S_D_WAIT, S_D_PTR, S_D_CHK, S_OUT
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] idx_reg;
    logic [9:0]    cnt_reg;
    logic          fin_reg;   // pass belongs to finish seeding
    logic          draw_reg;
    logic          ov_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_draw = draw_reg;
    // result register takes the new beat once the old one has left
    assign out_load = (state_reg == S_OUT) && (!ov_reg || out_ready);

    always_comb begin
        cmd.op = tmwp_pkg::OP_NONE;
        cmd.addr = idx_reg;
        case (state_reg)
            S_CLEAR: cmd.op = (idx_reg == '1 && cnt_reg[0]) ? tmwp_pkg::OP_CLR_REGS
                                                             : tmwp_pkg::OP_CLEAR;
            S_LOAD_RD: cmd.op = tmwp_pkg::OP_LOAD_RD;
            S_LOAD_WR: cmd.op = tmwp_pkg::OP_LOAD_WR;
            S_R0: cmd.op = tmwp_pkg::OP_R0;
            S_R1: cmd.op = tmwp_pkg::OP_R1;
            S_R2: cmd.op = tmwp_pkg::OP_R2;
            S_R3: cmd.op = tmwp_pkg::OP_ROT;
            S_ROT: cmd.addr = '1;
            S_PTR0: cmd.addr = AW'(1);
            // buffer address held so the read data stays valid into S_D_PTR
            S_D_RD, S_D_WAIT: cmd.op = tmwp_pkg::OP_DRAW_RD;
            S_D_PTR: cmd.op = tmwp_pkg::OP_DRAW_PTR;
            default: cmd.addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // clearing pass over both memories right after reset
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            draw_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (out_load) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        idx_reg <= '0;
                        cnt_reg <= in_count;
                        draw_reg <= (in_cmd == tmwp_pkg::CMD_DRAW);
                        case (in_cmd)
                            tmwp_pkg::CMD_INIT: begin
                                cnt_reg <= 10'd1;
                                state_reg <= S_CLEAR;
                            end
                            tmwp_pkg::CMD_LOAD: state_reg <= S_LOAD_RD;
                            tmwp_pkg::CMD_FINISH: begin
                                fin_reg <= 1'b1;
                                state_reg <= S_R0;
                            end
                            default: begin
                                fin_reg <= 1'b0;
                                state_reg <= S_D_RD;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == '1) begin
                        // the pass after reset returns no beat
                        state_reg <= cnt_reg[0] ? S_OUT : S_IDLE;
                    end
                end
                S_LOAD_RD: state_reg <= S_LOAD_WR;
                S_LOAD_WR: state_reg <= S_OUT;
                S_R0: state_reg <= S_R1;
                S_R1: state_reg <= S_R2;
                S_R2: state_reg <= S_R3;
                S_R3: begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= (idx_reg == '1) ? S_ROT : S_R0;
                end
                S_ROT: state_reg <= S_PTR0;
                S_PTR0: begin
                    if (fin_reg) begin
                        fin_reg <= 1'b0;
                        state_reg <= (cnt_reg == '0) ? S_OUT : S_D_PTR;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_D_RD: state_reg <= S_D_WAIT;
                S_D_WAIT: state_reg <= S_D_PTR;
                S_D_PTR: state_reg <= S_D_CHK;
                S_D_CHK: begin
                    if (stat.ptr_wrap) begin
                        idx_reg <= '0;
                        if (!draw_reg && cnt_reg != '0) begin
                            cnt_reg <= cnt_reg - 1'b1;
                            fin_reg <= 1'b1;
                        end
                        state_reg <= S_R0;
                    end else if (!draw_reg && cnt_reg > 10'd1) begin
                        cnt_reg <= cnt_reg - 1'b1;
                        state_reg <= S_D_PTR;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/table_mixing_word_prng.sv
// top level of the table-mixing word generator
// A command beat yields one result beat. A draw reads the buffer at the draw
// pointer and advances it, plus a mix pass of 256 rounds on every 256th draw;
// the rounds are serialized on the single port of the mixing table.
// Initialize sweeps both memories. Load is a table read, then a merged write;
// finish seeding takes a mix pass plus a pointer step per discarded draw.
// After reset a clearing pass runs with s_tready low. A result register lets the
// next command run while a result beat waits; the sequencer only stalls when
// its next result is ready and the previous one has not left.
module table_mixing_word_prng (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], word_index[7:2], seed_word[39:8], byte_enable[43:40],
    // discard_count[53:44]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // random_word[31:0], word_valid[32]
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic            extra_reg, rsw_reg;
    logic [55:0]     in_reg;
    logic            draw;
    logic            out_load;
    tmwp_pkg::cmd_t  cmd;
    tmwp_pkg::stat_t stat;
    logic [31:0]     buf_word;
    logic [31:0]     word_reg;
    logic            odraw_reg;
    logic [31:0]     oword_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extra_reg <= 1'b1;
            rsw_reg <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tmwp_pkg::REG_EXTRA_LOOKUP && paddr[1:0] == 2'b00) begin
                extra_reg <= pwdata[0];
            end
            if (paddr[2] == tmwp_pkg::REG_ROTATION_SWITCH && paddr[1:0] == 2'b00) begin
                rsw_reg <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == 3'd0) begin
            prdata[0] = extra_reg;
        end else if (paddr == 3'd4) begin
            prdata[0] = rsw_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata;
        end
        if (cmd.op == tmwp_pkg::OP_DRAW_PTR && draw) begin
            word_reg <= buf_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odraw_reg <= 1'b0;
            oword_reg <= '0;
        end else if (out_load) begin
            odraw_reg <= draw;
            oword_reg <= draw ? word_reg : 32'd0;
        end
    end

    tmwp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_count(s_tdata[53:44]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_draw(draw),
        .out_load(out_load), .cmd(cmd), .stat(stat)
    );

    tmwp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .extra_lookup(extra_reg), .rotation_switch(rsw_reg),
        .word_index(in_reg[7:2]), .seed_word(in_reg[39:8]),
        .byte_enable(in_reg[43:40]), .stat(stat), .buf_word(buf_word)
    );

    assign m_tdata = {7'd0, odraw_reg, oword_reg};
endmodule

// File: dv/table_mixing_word_prng_checker.sv
// checker for the table-mixing word generator: predicts and compares result beats
module table_mixing_word_prng_checker
    import tmwp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          words_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic        valid;
    } draw_result_t;

    localparam logic [4:0] ROT_I [4] = '{5'd30, 5'd5, 5'd21, 5'd29};
    localparam logic [4:0] ROT_J [4] = '{5'd13, 5'd19, 5'd4, 5'd15};
    localparam logic [4:0] ROT_K [4] = '{5'd24, 5'd20, 5'd10, 5'd6};

    logic [31:0]  tbl [TABLE_WORDS];
    logic [31:0]  buffer [TABLE_WORDS];
    logic [31:0]  cb, cc, cd;
    int unsigned  ptr;
    logic [1:0]   rset;
    logic         lookup_at_b;
    logic         switch_rot;
    draw_result_t result_q [$];
    int           fails = 0;
    int           pending = 0;

    assign fail_count = fails;
    assign words_pending = pending;

    function automatic logic [31:0] rot_left(logic [31:0] x, logic [4:0] k);
        return (k == 0) ? x : ((x << k) | (x >> (6'd32 - k)));
    endfunction

    task automatic clear_state();
        for (int i = 0; i < TABLE_WORDS; i++) begin
            tbl[i] = GOLDEN_WORD;
            buffer[i] = '0;
        end
        cb = GOLDEN_WORD;
        cc = GOLDEN_WORD;
        cd = GOLDEN_WORD;
        ptr = 0;
        rset = '0;
    endtask

    task automatic mix_rounds();
        logic [31:0] e;
        int at;
        for (int r = 0; r < TABLE_WORDS; r++) begin
            at = cd % TABLE_WORDS;
            e = tbl[at] - rot_left(cb, ROT_I[rset]);
            tbl[at] = cb ^ rot_left(cc, ROT_J[rset]);
            cb = cc + rot_left(cd, ROT_K[rset]);
            cc = cd + e;
            cd = e + (lookup_at_b ? tbl[cb % TABLE_WORDS] : tbl[r]);
            buffer[r] = cd;
        end
        if (switch_rot)
            rset = cc[1:0];
    endtask

    task automatic draw_next(output logic [31:0] w);
        w = buffer[ptr % TABLE_WORDS];
        ptr++;
        if (ptr >= TABLE_WORDS) begin
            mix_rounds();
            ptr = 0;
        end
    endtask

    task automatic predict(input logic [55:0] d);
        logic [1:0]  cmd;
        logic [5:0]  idx;
        logic [31:0] seed, m, w;
        logic [3:0]  be;
        logic [9:0]  cnt;
        draw_result_t res;
        cmd = d[1:0];
        idx = d[7:2];
        seed = d[39:8];
        be = d[43:40];
        cnt = d[53:44];
        res = '0;
        case (cmd)
            CMD_INIT: clear_state();
            CMD_LOAD: begin
                m = {{8{be[3]}}, {8{be[2]}}, {8{be[1]}}, {8{be[0]}}};
                if (idx < TABLE_WORDS)
                    tbl[idx] = (tbl[idx] & ~m) | (seed & m);
            end
            CMD_FINISH: begin
                mix_rounds();
                ptr = 0;
                for (int n = 0; n < cnt; n++)
                    draw_next(w);
            end
            default: begin
                draw_next(w);
                res.word = w;
                res.valid = 1'b1;
            end
        endcase
        result_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        draw_result_t exp_r;
        if (!aresetn) begin
            clear_state();
            lookup_at_b = 1'b1;
            switch_rot = 1'b1;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[2] == REG_ROTATION_SWITCH)
                    switch_rot = pwdata[0];
                else
                    lookup_at_b = pwdata[0];
            end
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    fails++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_tdata[31:0] !== exp_r.word) begin
                        $error("random_word expected %h actual %h", exp_r.word,
                               m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[32] !== exp_r.valid) begin
                        $error("word_valid expected %b actual %b", exp_r.valid,
                               m_tdata[32]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict(s_tdata);
        end
        pending <= result_q.size();
    end

endmodule

// File: dv/table_mixing_word_prng_tb.sv
// testbench top for the table-mixing word generator: stimulus and verdict
module table_mixing_word_prng_tb;
    import tmwp_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 1200;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, words_pending;
    int          idle_cycles = 0;
    logic        hold_req;

    table_mixing_word_prng DUT (.*);

    table_mixing_word_prng_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // no-progress watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random ready gaps, one long hold on request
    initial begin
        int g;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                held = 1'b1;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            g = pick_gap();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [31:0] seed, input logic [3:0] be,
                             input logic [9:0] cnt);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, cnt, be, seed, idx, cmd};
        do @(posedge aclk); while (!s_tready);
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic draw_beat();
        send_beat(CMD_DRAW, 6'($urandom), $urandom, 4'($urandom), 10'($urandom));
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input logic lookup, input logic rot);
        drain();
        reg_write(REG_EXTRA_LOOKUP, {31'd0, lookup});
        reg_write(REG_ROTATION_SWITCH, {31'd0, rot});
    endtask

    // seeding run with random content, then a burst of draws with an occasional random command
    task automatic seeded_run(ref int items);
        int nload, ndraw;
        logic [9:0] cnt;
        if ($urandom_range(0, 3) == 0) begin
            send_beat(CMD_INIT, 6'($urandom), $urandom, 4'($urandom), 10'($urandom));
            items++;
        end
        nload = $urandom_range(0, 8);
        for (int i = 0; i < nload; i++) begin
            send_beat(CMD_LOAD, 6'($urandom), $urandom, 4'($urandom), 10'($urandom));
            items++;
        end
        if ($urandom_range(0, 4) != 0) begin
            cnt = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
            send_beat(CMD_FINISH, 6'($urandom), $urandom, 4'($urandom), cnt);
            items++;
        end
        ndraw = $urandom_range(5, 70);
        for (int i = 0; i < ndraw; i++) begin
            if ($urandom_range(0, 29) == 0)
                send_beat(2'($urandom), 6'($urandom), $urandom, 4'($urandom),
                          10'($urandom_range(0, 5)));
            else
                draw_beat();
            items++;
        end
    endtask

    initial begin
        int items;
        logic [1:0] modes [4];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of each field and every command
        draw_beat();
        send_beat(CMD_LOAD, 6'd0, 32'hffffffff, 4'hf, 10'd0);
        send_beat(CMD_LOAD, 6'd63, 32'h00000000, 4'hf, 10'h3ff);
        send_beat(CMD_LOAD, 6'd21, 32'hdeadbeef, 4'h0, 10'd0);
        send_beat(CMD_LOAD, 6'd42, 32'h12345678, 4'h5, 10'd0);
        send_beat(CMD_LOAD, 6'd7, 32'hcafef00d, 4'ha, 10'd0);
        send_beat(CMD_FINISH, 6'd0, 32'd0, 4'd0, 10'd0);
        draw_beat();
        draw_beat();
        send_beat(CMD_FINISH, 6'd63, 32'hffffffff, 4'hf, 10'd1);
        draw_beat();
        send_beat(CMD_FINISH, 6'd0, 32'd0, 4'd0, 10'h3ff);
        draw_beat();
        send_beat(CMD_FINISH, 6'd0, 32'd0, 4'd0, 10'd255);
        draw_beat();
        send_beat(CMD_INIT, 6'd63, 32'hffffffff, 4'hf, 10'h3ff);
        draw_beat();
        send_beat(CMD_DRAW, 6'd63, 32'hffffffff, 4'hf, 10'h3ff);
        send_beat(CMD_INIT, 6'd0, 32'd0, 4'd0, 10'd0);

        modes = '{2'b01, 2'b10, 2'b00, 2'b11};
        items = 0;
        for (int p = 0; p < 4; p++) begin
            set_mode(modes[p][1], modes[p][0]);
            if (p == 1)
                hold_req = 1'b1;
            while (items < (p + 1) * 330)
                seeded_run(items);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tmwp_pkg.sv
rtl/tmwp_ram.sv
rtl/tmwp_datapath.sv
rtl/tmwp_ctrl.sv
rtl/table_mixing_word_prng.sv
dv/table_mixing_word_prng_checker.sv
dv/table_mixing_word_prng_tb.sv
